### hw/rtl/cwmf_pkg.sv
// shared types and codes for the clipped window median filter
package cwmf_pkg;

    localparam int COORD_W = 9;
    localparam int CFG_W   = 9;
    localparam int IDX_W   = 2;

    typedef enum logic [IDX_W-1:0] {
        CFG_IMAGE_WIDTH  = 2'd0,
        CFG_IMAGE_HEIGHT = 2'd1,
        CFG_WINDOW_SIZE  = 2'd2
    } t_cfg_idx;

    typedef enum logic {
        KIND_LOAD  = 1'b0,
        KIND_QUERY = 1'b1
    } t_kind;

    typedef struct packed {
        logic take_query; // latch query position
        logic wr_pixel;   // write load item into frame
        logic setup;      // compute clipped window bounds
        logic rd;         // read one window pixel and step
        logic shift;      // shift sort buffer toward head
        logic post;       // load output register
    } t_cmd;

    typedef struct packed {
        logic oob;
        logic last_rd;
        logic sel_done;
        logic out_free;
    } t_stat;

endpackage

### hw/rtl/cwmf_ctrl.sv
// controller state machine for the median filter
module cwmf_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  logic           i_in_kind,
    output logic           o_in_ready,
    input  cwmf_pkg::t_stat i_stat,
    output cwmf_pkg::t_cmd  o_cmd
);
    import cwmf_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE, ST_SETUP, ST_READ, ST_DRAIN, ST_SEL, ST_DONE
    } t_state;

    t_state r_state, n_state;

    assign o_in_ready = (r_state == ST_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    if (i_in_kind == KIND_QUERY) begin
                        o_cmd.take_query = 1'b1;
                        n_state = ST_SETUP;
                    end else begin
                        o_cmd.wr_pixel = 1'b1;
                    end
                end
            end
            ST_SETUP: begin
                o_cmd.setup = 1'b1;
                n_state = i_stat.oob ? ST_DONE : ST_READ;
            end
            ST_READ: begin
                o_cmd.rd = 1'b1;
                if (i_stat.last_rd) n_state = ST_DRAIN;
            end
            ST_DRAIN: begin
                n_state = ST_SEL;
            end
            ST_SEL: begin
                if (i_stat.sel_done) n_state = ST_DONE;
                else o_cmd.shift = 1'b1;
            end
            ST_DONE: begin
                if (i_stat.out_free) begin
                    o_cmd.post = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= ST_IDLE;
        else r_state <= n_state;
    end

endmodule

### hw/rtl/cwmf_dp.sv
// datapath: config, frame store, window walk, insertion sort cells, output register
module cwmf_dp #(
    parameter int MAX_WIDTH       = 256,
    parameter int MAX_HEIGHT      = 256,
    parameter int PIXEL_BITS      = 8,
    parameter int MAX_WINDOW_SIDE = 9
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_wr_en,
    input  logic [1:0]            i_cfg_index,
    input  logic [8:0]            i_cfg_wdata,
    input  logic [7:0]            i_row,
    input  logic [7:0]            i_col,
    input  logic [7:0]            i_pixel,
    input  cwmf_pkg::t_cmd        i_cmd,
    output cwmf_pkg::t_stat       o_stat,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [7:0]            o_median,
    output logic [6:0]            o_count,
    output logic                  o_oob
);
    import cwmf_pkg::*;

    localparam int HALF_MAX = MAX_WINDOW_SIDE / 2;
    localparam int WIN_MAX  = MAX_WINDOW_SIDE * MAX_WINDOW_SIDE;
    localparam int NW       = $clog2(WIN_MAX + 1);
    localparam int DEPTH    = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW       = $clog2(DEPTH);

    logic [CFG_W-1:0]   r_cfg_w, r_cfg_h;
    logic [3:0]         r_cfg_ws;
    logic [COORD_W-1:0] r_row, r_col, r_r, r_c, r_c0, r_r1, r_c1;
    logic [COORD_W-1:0] w_eff, h_eff;
    logic [2:0]         half;
    logic [PIXEL_BITS-1:0] mem [DEPTH];
    logic [PIXEL_BITS-1:0] r_rd_data;
    logic               r_ins;
    logic [PIXEL_BITS-1:0] r_buf [WIN_MAX];
    logic [PIXEL_BITS-1:0] n_buf [WIN_MAX];
    logic [NW-1:0]      r_n, r_sh;
    logic [WIN_MAX-1:0] ge;
    logic [AW-1:0]      wr_addr, rd_addr;
    logic               r_out_valid, r_oob_q;
    logic [7:0]         r_median;
    logic [6:0]         r_count;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_w  <= 9'd256;
            r_cfg_h  <= 9'd256;
            r_cfg_ws <= 4'd3;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                CFG_IMAGE_WIDTH:  r_cfg_w  <= i_cfg_wdata;
                CFG_IMAGE_HEIGHT: r_cfg_h  <= i_cfg_wdata;
                CFG_WINDOW_SIZE:  r_cfg_ws <= i_cfg_wdata[3:0];
                default: ;
            endcase
        end
    end

    assign w_eff = (32'(r_cfg_w) > MAX_WIDTH)  ? COORD_W'(MAX_WIDTH)  : r_cfg_w;
    assign h_eff = (32'(r_cfg_h) > MAX_HEIGHT) ? COORD_W'(MAX_HEIGHT) : r_cfg_h;
    assign half  = (32'(r_cfg_ws[3:1]) > HALF_MAX) ? 3'(HALF_MAX) : r_cfg_ws[3:1];

    assign o_stat.oob      = (r_row >= h_eff) || (r_col >= w_eff);
    assign o_stat.last_rd  = (r_r == r_r1) && (r_c == r_c1);
    assign o_stat.sel_done = (r_sh == (r_n >> 1));
    assign o_stat.out_free = !r_out_valid || i_out_ready;

    // window walk
    always_ff @(posedge i_clk) begin
        if (i_cmd.take_query) begin
            r_row <= COORD_W'(i_row);
            r_col <= COORD_W'(i_col);
        end
        if (i_cmd.setup) begin
            r_r  <= (r_row >= COORD_W'(half)) ? r_row - COORD_W'(half) : '0;
            r_c  <= (r_col >= COORD_W'(half)) ? r_col - COORD_W'(half) : '0;
            r_c0 <= (r_col >= COORD_W'(half)) ? r_col - COORD_W'(half) : '0;
            r_r1 <= (r_row + COORD_W'(half) > h_eff - 1'b1) ? h_eff - 1'b1
                                                            : r_row + COORD_W'(half);
            r_c1 <= (r_col + COORD_W'(half) > w_eff - 1'b1) ? w_eff - 1'b1
                                                            : r_col + COORD_W'(half);
        end else if (i_cmd.rd) begin
            if (r_c == r_c1) begin
                r_c <= r_c0;
                r_r <= r_r + 1'b1;
            end else begin
                r_c <= r_c + 1'b1;
            end
        end
    end

    // frame store
    assign wr_addr = AW'(i_row) * AW'(MAX_WIDTH) + AW'(i_col);
    assign rd_addr = AW'(r_r) * AW'(MAX_WIDTH) + AW'(r_c);

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_pixel && (32'(i_row) < MAX_HEIGHT) && (32'(i_col) < MAX_WIDTH))
            mem[wr_addr] <= PIXEL_BITS'(i_pixel);
        if (i_cmd.rd)
            r_rd_data <= mem[rd_addr];
    end

    // sorted descending; new value goes after all entries >= it
    always_comb begin
        for (int i = 0; i < WIN_MAX; i++) ge[i] = (r_buf[i] >= r_rd_data);
        n_buf[0] = r_buf[0];
        if (r_n == '0 || !ge[0]) n_buf[0] = r_rd_data;
        for (int i = 1; i < WIN_MAX; i++) begin
            n_buf[i] = r_buf[i];
            if (NW'(i) <= r_n && (NW'(i) == r_n || !ge[i])) begin
                n_buf[i] = ge[i-1] ? r_rd_data : r_buf[i-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ins <= 1'b0;
        end else begin
            r_ins <= i_cmd.rd;
        end
        if (i_cmd.setup) begin
            r_n  <= '0;
            r_sh <= '0;
        end else if (r_ins) begin
            r_buf <= n_buf;
            r_n   <= r_n + 1'b1;
        end else if (i_cmd.shift) begin
            for (int i = 0; i < WIN_MAX - 1; i++) r_buf[i] <= r_buf[i+1];
            r_sh <= r_sh + 1'b1;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.post) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
        if (i_cmd.post) begin
            r_oob_q  <= o_stat.oob;
            r_median <= o_stat.oob ? 8'd0 : 8'(r_buf[0]);
            r_count  <= o_stat.oob ? 7'd0 : 7'(r_n);
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_median    = r_median;
    assign o_count     = r_count;
    assign o_oob       = r_oob_q;

endmodule

### hw/rtl/clipped_window_median_filter.sv
// top level of the clipped window median filter
//
//  channel   direction  tdata (low bit up)                  tuser
//  s_axis    in         row[7:0] col[15:8] pixel[23:16]     kind
//  m_axis    out        median[7:0] window_count[14:8]      out_of_image
//  cfg       in         index 0 width, 1 height, 2 window size
//
// a query reads its clipped window of n pixels (up to 81 for a 9x9 window)
// through the single read port of the frame store, one pixel a cycle, then
// makes one shift per step toward the median slot. reset is synchronous,
// active low; the frame store is not cleared. a waiting result holds the
// block only when the next query finishes; loads keep flowing.
module clipped_window_median_filter #(
    parameter int MAX_WIDTH       = 256,
    parameter int MAX_HEIGHT      = 256,
    parameter int PIXEL_BITS      = 8,
    parameter int MAX_WINDOW_SIDE = 9
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [1:0]  i_cfg_index,
    input  logic [8:0]  i_cfg_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,  // row, col, pixel
    input  logic        s_axis_tuser,  // kind
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,  // median, window_count, zero pad
    output logic        m_axis_tuser   // out_of_image
);
    import cwmf_pkg::*;

    t_cmd       cmd;
    t_stat      stat;
    logic [6:0] count;
    logic [7:0] median;

    cwmf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_in_kind  (s_axis_tuser),
        .o_in_ready (s_axis_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    cwmf_dp #(
        .MAX_WIDTH       (MAX_WIDTH),
        .MAX_HEIGHT      (MAX_HEIGHT),
        .PIXEL_BITS      (PIXEL_BITS),
        .MAX_WINDOW_SIDE (MAX_WINDOW_SIDE)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .i_row       (s_axis_tdata[7:0]),
        .i_col       (s_axis_tdata[15:8]),
        .i_pixel     (s_axis_tdata[23:16]),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_median    (median),
        .o_count     (count),
        .o_oob       (m_axis_tuser)
    );

    assign m_axis_tdata = {1'b0, count, median};

endmodule

### tb/testbench.sv
// self-checking testbench for the clipped window median filter
`timescale 1ns / 1ps

import cwmf_pkg::*;

typedef struct {
    bit [7:0] median;
    bit [6:0] count;
    bit       oob;
} median_result_t;

class median_scoreboard;
    bit [7:0]       frame [0:65535];
    int unsigned    width = 256;
    int unsigned    height = 256;
    int unsigned    wsize = 3;
    median_result_t medians_due [$];
    int             errors = 0;

    function void set_reg(t_cfg_idx idx, bit [8:0] value);
        case (idx)
            CFG_IMAGE_WIDTH:  width = value;
            CFG_IMAGE_HEIGHT: height = value;
            CFG_WINDOW_SIZE:  wsize = value[3:0];
            default: ;
        endcase
    endfunction

    // clipped window bounds; returns 0 when the position is outside the frame
    function bit window_of(int r, int c, output int r0, output int r1,
                           output int c0, output int c1);
        int w;
        int h;
        int half;
        w = (width > 256) ? 256 : width;
        h = (height > 256) ? 256 : height;
        if (r >= h || c >= w)
            return 0;
        half = wsize / 2;
        if (half > 4)
            half = 4;
        r0 = (r >= half) ? r - half : 0;
        c0 = (c >= half) ? c - half : 0;
        r1 = (r + half > h - 1) ? h - 1 : r + half;
        c1 = (c + half > w - 1) ? w - 1 : c + half;
        return 1;
    endfunction

    function void note_input(t_kind kind, bit [7:0] r, bit [7:0] c, bit [7:0] p);
        median_result_t res;
        bit [7:0]       vals [$];
        int             r0, r1, c0, c1;
        if (kind == KIND_LOAD) begin
            frame[{r, c}] = p;
            return;
        end
        res = '{median: 0, count: 0, oob: 1};
        if (window_of(r, c, r0, r1, c0, c1)) begin
            for (int y = r0; y <= r1; y++)
                for (int x = c0; x <= c1; x++)
                    vals.push_back(frame[y * 256 + x]);
            vals.rsort();
            res.median = vals[vals.size() / 2];
            res.count = vals.size();
            res.oob = 0;
        end
        medians_due.push_back(res);
    endfunction

    function void check_result(bit [7:0] median, bit [6:0] count, bit oob);
        median_result_t exp_res;
        if (medians_due.size() == 0) begin
            $error("unexpected result median=%0d count=%0d oob=%0d", median, count, oob);
            errors++;
            return;
        end
        exp_res = medians_due.pop_front();
        if (median !== exp_res.median) begin
            $error("median: expected %0d, got %0d", exp_res.median, median);
            errors++;
        end
        if (count !== exp_res.count) begin
            $error("window_count: expected %0d, got %0d", exp_res.count, count);
            errors++;
        end
        if (oob !== exp_res.oob) begin
            $error("out_of_image: expected %0d, got %0d", exp_res.oob, oob);
            errors++;
        end
    endfunction
endclass

module testbench;
    localparam int STALL_LIMIT = 20000;

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        cfg_wr_en = 0;
    logic [1:0]  cfg_index = '0;
    logic [8:0]  cfg_wdata = '0;
    logic        s_valid = 0;
    logic        s_ready;
    logic [23:0] s_data = '0;
    logic        s_user = 0;
    logic        m_valid;
    logic        m_ready = 0;
    logic [15:0] m_data;
    logic        m_user;

    median_scoreboard sb;
    bit  written [0:65535];
    int  src_idle = 0;
    int  sink_stall = 0;
    int  items_sent = 0;
    int  quiet_cycles = 0;

    clipped_window_median_filter uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_wr_en  (cfg_wr_en),
        .i_cfg_index  (cfg_index),
        .i_cfg_wdata  (cfg_wdata),
        .s_axis_tvalid(s_valid),
        .s_axis_tready(s_ready),
        .s_axis_tdata (s_data),   // row, col, pixel
        .s_axis_tuser (s_user),   // kind
        .m_axis_tvalid(m_valid),
        .m_axis_tready(m_ready),
        .m_axis_tdata (m_data),   // median, window_count, zero pad
        .m_axis_tuser (m_user)    // out_of_image
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    always @(negedge i_clk) begin
        m_ready <= ($urandom_range(99) >= sink_stall);
    end

    always @(posedge i_clk) begin
        if (m_valid && m_ready)
            sb.check_result(m_data[7:0], m_data[14:8], m_user);
        if ((m_valid && m_ready) || (s_valid && s_ready) || !i_rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("testbench NOT OK");
            $finish;
        end
    end

    // every task starts and ends just after a falling edge
    task automatic send_item(t_kind kind, bit [7:0] r, bit [7:0] c, bit [7:0] p);
        while ($urandom_range(99) < src_idle) begin
            s_valid <= 0;
            @(negedge i_clk);
        end
        s_valid <= 1;
        s_user <= kind;
        s_data <= {p, c, r};
        do @(posedge i_clk); while (!s_ready);
        sb.note_input(kind, r, c, p);
        items_sent++;
        @(negedge i_clk);
    endtask

    task automatic load_at(bit [7:0] r, bit [7:0] c, bit [7:0] p);
        written[{r, c}] = 1;
        send_item(KIND_LOAD, r, c, p);
    endtask

    // loads any window pixel not yet written, then queries
    task automatic query_at(bit [7:0] r, bit [7:0] c);
        int r0, r1, c0, c1;
        if (sb.window_of(r, c, r0, r1, c0, c1))
            for (int y = r0; y <= r1; y++)
                for (int x = c0; x <= c1; x++)
                    if (!written[y * 256 + x])
                        load_at(y, x, $urandom_range(255));
        send_item(KIND_QUERY, r, c, $urandom_range(255));
    endtask

    task automatic write_reg(t_cfg_idx idx, bit [8:0] value);
        s_valid <= 0;
        while (sb.medians_due.size() != 0)
            @(negedge i_clk);
        repeat (200) @(negedge i_clk);
        cfg_wr_en <= 1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(negedge i_clk);
        cfg_wr_en <= 0;
        sb.set_reg(idx, value);
    endtask

    task automatic set_frame(bit [8:0] w, bit [8:0] h, bit [8:0] ws);
        write_reg(CFG_IMAGE_WIDTH, w);
        write_reg(CFG_IMAGE_HEIGHT, h);
        write_reg(CFG_WINDOW_SIZE, ws);
    endtask

    // coordinate near either edge of a dimension, sometimes just past it
    function automatic bit [7:0] near_edge(int unsigned lim);
        int v;
        if (lim > 256)
            lim = 256;
        if (lim == 0)
            return $urandom_range(255);
        if ($urandom_range(9) == 0)
            v = lim + $urandom_range(3);
        else if ($urandom_range(1))
            v = $urandom_range(6);
        else
            v = int'(lim) - 1 - int'($urandom_range(6));
        if (v < 0)
            v = 0;
        if (v > 255)
            v = 255;
        return v;
    endfunction

    task automatic run_phase(bit [8:0] w, bit [8:0] h, bit [8:0] ws,
                             int idle_pct, int stall_pct, int n_items);
        int target;
        int pick;
        set_frame(w, h, ws);
        src_idle = idle_pct;
        sink_stall = stall_pct;
        target = items_sent + n_items;
        while (items_sent < target) begin
            pick = $urandom_range(99);
            if (pick < 30)
                load_at(near_edge(sb.height), near_edge(sb.width), $urandom_range(255));
            else if (pick < 95)
                query_at(near_edge(sb.height), near_edge(sb.width));
            else
                query_at($urandom_range(255), $urandom_range(255));
        end
    endtask

    initial begin
        sb = new();
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1;
        @(negedge i_clk);

        // directed: corners with extreme pixel values, reset settings
        load_at(0, 0, 8'd0);
        load_at(0, 1, 8'd255);
        load_at(1, 0, 8'd255);
        load_at(1, 1, 8'd0);
        query_at(0, 0);
        load_at(255, 255, 8'd255);
        query_at(255, 255);
        query_at(128, 127);
        // zero-sized frame: always out of image
        set_frame(0, 256, 3);
        query_at(0, 0);
        // oversized frame and saturated window
        set_frame(511, 300, 15);
        query_at(255, 0);
        query_at(4, 4);
        // size zero gives a single pixel
        set_frame(256, 256, 0);
        query_at(1, 1);
        // one pixel frame
        set_frame(1, 1, 9);
        query_at(0, 0);
        query_at(0, 1);
        query_at(1, 0);
        // two pixels: lower median of an even count
        set_frame(2, 1, 3);
        query_at(0, 0);
        query_at(0, 2);

        run_phase(256, 256, 3, 0, 0, 220);
        run_phase(16, 12, 9, 68, 0, 220);
        run_phase(256, 256, 15, 0, 68, 220);
        run_phase(1, 256, 5, 31, 31, 200);
        run_phase(7, 300, 0, 68, 68, 200);
        run_phase(40, 40, 4, 31, 31, 220);
        run_phase(256, 1, 8, 0, 0, 200);

        s_valid <= 0;
        while (sb.medians_due.size() != 0)
            @(negedge i_clk);
        repeat (200) @(negedge i_clk);
        if (sb.errors == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end
endmodule
